// ----- sv/i2cms_pkg.sv -----
// Shared constants, command codes and types for the I2C master byte sequencer.
`timescale 1ns / 1ps

package i2cms_pkg;

  localparam int MODE_W       = 3;
  localparam int BYTE_W       = 8;
  localparam int DEF_BITS_PER_BYTE = 8;

  // Command codes carried in the mode field
  localparam logic [MODE_W-1:0] MODE_START   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RESTART = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STOP    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;

  // One line assignment as seen on the result channel
  typedef struct packed {
    logic              scl;
    logic              sda;
    logic [BYTE_W-1:0] read_byte;
    logic              last;
  } step_t;

endpackage

// ----- sv/i2cms_if.sv -----
// Command and result channel interfaces for the I2C master byte sequencer.
`timescale 1ns / 1ps

interface i2cms_in_if;
  import i2cms_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] byte_value;
  logic              send_ack;
  logic [BYTE_W-1:0] line_bits;

  modport source (output valid, output mode, output byte_value, output send_ack,
                  output line_bits, input ready);
  modport sink   (input valid, input mode, input byte_value, input send_ack,
                  input line_bits, output ready);
endinterface

interface i2cms_out_if;
  import i2cms_pkg::*;

  logic              valid;
  logic              ready;
  logic              scl;
  logic              sda;
  logic [BYTE_W-1:0] read_byte;
  logic              last;

  modport source (output valid, output scl, output sda, output read_byte,
                  output last, input ready);
  modport sink   (input valid, input scl, input sda, input read_byte,
                  input last, output ready);
endinterface

// ----- sv/i2cms_seq.sv -----
// Bus phase sequencer: one SCL or SDA assignment per step around a shared shift register.
`timescale 1ns / 1ps

module i2cms_seq #(
  parameter int BITS_PER_BYTE = i2cms_pkg::DEF_BITS_PER_BYTE
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  logic [i2cms_pkg::MODE_W-1:0]   mode,
  input  logic [i2cms_pkg::BYTE_W-1:0]   byte_value,
  input  logic                           send_ack,
  input  logic [i2cms_pkg::BYTE_W-1:0]   line_bits,
  input  logic                           adv,
  output logic                           busy,
  output i2cms_pkg::step_t               step
);
  import i2cms_pkg::*;

  localparam int CW = $clog2(BITS_PER_BYTE + 1);
  localparam logic [CW-1:0] CNT_END = CW'(BITS_PER_BYTE - 1);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_RS_SDA  = 5'd1;
  localparam logic [4:0] S_RS_SCL  = 5'd2;
  localparam logic [4:0] S_ST_SDA  = 5'd3;
  localparam logic [4:0] S_ST_SCL  = 5'd4;
  localparam logic [4:0] S_WB_SDA  = 5'd5;
  localparam logic [4:0] S_WB_SCLH = 5'd6;
  localparam logic [4:0] S_WB_SCLL = 5'd7;
  localparam logic [4:0] S_WA_SDA  = 5'd8;
  localparam logic [4:0] S_WA_SCLH = 5'd9;
  localparam logic [4:0] S_WA_SCLL = 5'd10;
  localparam logic [4:0] S_SP_SDA0 = 5'd11;
  localparam logic [4:0] S_SP_SCL  = 5'd12;
  localparam logic [4:0] S_SP_SDA1 = 5'd13;
  localparam logic [4:0] S_RB_SDA  = 5'd14;
  localparam logic [4:0] S_RB_SCLH = 5'd15;
  localparam logic [4:0] S_RB_SCLL = 5'd16;
  localparam logic [4:0] S_RA_SDA  = 5'd17;
  localparam logic [4:0] S_RA_SCLH = 5'd18;
  localparam logic [4:0] S_RA_SCLL = 5'd19;

  logic [4:0]        state_r, state_nxt, nst;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] sh_r, sh_nxt;
  logic [BYTE_W-1:0] acc_r, acc_nxt;
  logic              ack_r, ack_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic              e_scl, e_sda, e_last;
  logic              do_shift, do_sample, cnt_step;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    e_scl     = scl_r;
    e_sda     = sda_r;
    e_last    = 1'b0;
    nst       = state_r;
    do_shift  = 1'b0;
    do_sample = 1'b0;
    cnt_step  = 1'b0;
    case (state_r)
      S_RS_SDA:  begin e_sda = 1'b1; nst = S_RS_SCL; end
      S_RS_SCL:  begin e_scl = 1'b1; nst = S_ST_SDA; end
      S_ST_SDA:  begin e_sda = 1'b0; nst = S_ST_SCL; end
      S_ST_SCL:  begin e_scl = 1'b0; nst = S_WB_SDA; end
      S_WB_SDA:  begin e_sda = sh_r[BYTE_W-1]; do_shift = 1'b1; nst = S_WB_SCLH; end
      S_WB_SCLH: begin e_scl = 1'b1; nst = S_WB_SCLL; end
      S_WB_SCLL: begin
        e_scl    = 1'b0;
        cnt_step = 1'b1;
        nst      = (cnt_r == CNT_END) ? S_WA_SDA : S_WB_SDA;
      end
      S_WA_SDA:  begin e_sda = 1'b1; nst = S_WA_SCLH; end
      S_WA_SCLH: begin e_scl = 1'b1; nst = S_WA_SCLL; end
      S_WA_SCLL: begin e_scl = 1'b0; e_last = 1'b1; nst = S_IDLE; end
      S_SP_SDA0: begin e_sda = 1'b0; nst = S_SP_SCL; end
      S_SP_SCL:  begin e_scl = 1'b1; nst = S_SP_SDA1; end
      S_SP_SDA1: begin e_sda = 1'b1; e_last = 1'b1; nst = S_IDLE; end
      S_RB_SDA:  begin e_sda = 1'b1; nst = S_RB_SCLH; end
      S_RB_SCLH: begin e_scl = 1'b1; do_sample = 1'b1; nst = S_RB_SCLL; end
      S_RB_SCLL: begin
        e_scl    = 1'b0;
        cnt_step = 1'b1;
        if (cnt_r != CNT_END) nst = S_RB_SCLH;
        else if (ack_r)       nst = S_RA_SDA;
        else                  nst = S_RA_SCLH;
      end
      S_RA_SDA:  begin e_sda = 1'b0; nst = S_RA_SCLH; end
      S_RA_SCLH: begin e_scl = 1'b1; nst = S_RA_SCLL; end
      S_RA_SCLL: begin e_scl = 1'b0; e_last = 1'b1; nst = S_IDLE; end
      default:   nst = S_IDLE;
    endcase
  end

  always_comb begin
    step.scl       = e_scl;
    step.sda       = e_sda;
    step.last      = e_last;
    step.read_byte = (e_last && state_r == S_RA_SCLL) ? acc_r : '0;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sh_nxt    = sh_r;
    acc_nxt   = acc_r;
    ack_nxt   = ack_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    if (load) begin
      cnt_nxt = '0;
      acc_nxt = '0;
      ack_nxt = send_ack;
      sh_nxt  = (mode == MODE_READ) ? line_bits : byte_value;
      case (mode)
        MODE_START:   state_nxt = S_ST_SDA;
        MODE_RESTART: state_nxt = S_RS_SDA;
        MODE_STOP:    state_nxt = S_SP_SDA0;
        MODE_WRITE:   state_nxt = S_WB_SDA;
        MODE_READ:    state_nxt = S_RB_SDA;
        default:      state_nxt = S_IDLE;
      endcase
    end else if (adv) begin
      state_nxt = nst;
      scl_nxt   = e_scl;
      sda_nxt   = e_sda;
      // write bits past the byte are zero, read samples past it see a released line
      if (do_shift)  sh_nxt = {sh_r[BYTE_W-2:0], 1'b0};
      if (do_sample) begin
        acc_nxt = {acc_r[BYTE_W-2:0], sh_r[BYTE_W-1]};
        sh_nxt  = {sh_r[BYTE_W-2:0], 1'b1};
      end
      if (cnt_step) cnt_nxt = (cnt_r == CNT_END) ? '0 : cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    acc_r <= acc_nxt;
    ack_r <= ack_nxt;
  end

endmodule

// ----- sv/i2c_master_byte_sequencer.sv -----
// An accepted command is registered into the sequencer state; each line change then goes to out_r.
// Throughput: one line change per cycle while out_ch is ready; a command yields its result
//   count of line changes (3 for stop, up to 31 results for restart at 8 bits per byte).
// The phase sequencer issues one SCL or SDA assignment per cycle while it advances.
// Reset: synchronous active low; SCL and SDA levels return to released (1), sequencer idles.
`timescale 1ns / 1ps

module i2c_master_byte_sequencer #(
  parameter int BITS_PER_BYTE = i2cms_pkg::DEF_BITS_PER_BYTE
) (
  input  logic          clk,
  input  logic          rst_n,
  i2cms_in_if.sink      in_ch,
  i2cms_out_if.source   out_ch
);
  import i2cms_pkg::*;

  logic  busy;
  logic  load;
  logic  adv;
  step_t step;
  step_t out_r;
  logic  out_valid_r;

  assign in_ch.ready = !busy;
  assign load        = in_ch.valid && !busy;
  // advance while busy whenever the output register is empty or being emptied
  assign adv         = busy && (!out_valid_r || out_ch.ready);

  i2cms_seq #(
    .BITS_PER_BYTE (BITS_PER_BYTE)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .mode       (in_ch.mode),
    .byte_value (in_ch.byte_value),
    .send_ack   (in_ch.send_ack),
    .line_bits  (in_ch.line_bits),
    .adv        (adv),
    .busy       (busy),
    .step       (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= step;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.scl       = out_r.scl;
  assign out_ch.sda       = out_r.sda;
  assign out_ch.read_byte = out_r.read_byte;
  assign out_ch.last      = out_r.last;

endmodule

// ----- tb/tb_i2c_master_byte_sequencer.sv -----
// Self-checking testbench for the I2C master byte sequencer: command stimulus, line-change checks.
`timescale 1ns / 1ps

module tb_i2c_master_byte_sequencer;
  import i2cms_pkg::*;

  localparam int BITS         = DEF_BITS_PER_BYTE;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] byte_value;
    logic              send_ack;
    logic [BYTE_W-1:0] line_bits;
  } bus_cmd_t;

  logic clk;
  logic rst_n;

  i2cms_in_if  in_ch ();
  i2cms_out_if out_ch ();

  i2c_master_byte_sequencer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted bus line levels and the line changes still to come
  logic  scl_line;
  logic  sda_line;
  step_t expected_steps[$];

  int tx_idle_pct;
  int rx_stall_pct;
  int hold_req_count;
  int line_errors;
  int steps_checked;
  int commands_sent;
  int mode_count[8];
  int quiet_cycles;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void push_step();
    expected_steps.push_back('{scl: scl_line, sda: sda_line, read_byte: '0, last: 1'b0});
  endfunction

  function automatic void put_scl(logic v);
    scl_line = v;
    push_step();
  endfunction

  function automatic void put_sda(logic v);
    sda_line = v;
    push_step();
  endfunction

  // MSB first; bits past the eighth shift in as 0, then the ACK clock with SDA released
  function automatic void shift_out(logic [BYTE_W-1:0] data);
    for (int i = 0; i < BITS; i++) begin
      put_sda(data[BYTE_W-1]);
      data = data << 1;
      put_scl(1'b1);
      put_scl(1'b0);
    end
    put_sda(1'b1);
    put_scl(1'b1);
    put_scl(1'b0);
  endfunction

  // Samples past the eighth see a released line
  function automatic logic [BYTE_W-1:0] shift_in(logic ack, logic [BYTE_W-1:0] line);
    logic [BYTE_W-1:0] rd;
    rd = '0;
    put_sda(1'b1);
    for (int i = 0; i < BITS; i++) begin
      rd = rd << 1;
      put_scl(1'b1);
      rd[0] = line[BYTE_W-1];
      line = {line[BYTE_W-2:0], 1'b1};
      put_scl(1'b0);
    end
    if (ack) put_sda(1'b0);
    put_scl(1'b1);
    put_scl(1'b0);
    return rd;
  endfunction

  function automatic void predict_line_changes(bus_cmd_t c);
    int                base;
    logic [BYTE_W-1:0] rd;
    step_t             tail;
    base = expected_steps.size();
    rd = '0;
    case (c.mode)
      MODE_START: begin
        put_sda(1'b0);
        put_scl(1'b0);
        shift_out(c.byte_value);
      end
      MODE_RESTART: begin
        put_sda(1'b1);
        put_scl(1'b1);
        put_sda(1'b0);
        put_scl(1'b0);
        shift_out(c.byte_value);
      end
      MODE_STOP: begin
        put_sda(1'b0);
        put_scl(1'b1);
        put_sda(1'b1);
      end
      MODE_WRITE: shift_out(c.byte_value);
      MODE_READ:  rd = shift_in(c.send_ack, c.line_bits);
      default: ;
    endcase
    // mark the final line change of the command and attach the read data
    if (expected_steps.size() > base) begin
      tail = expected_steps.pop_back();
      tail.read_byte = rd;
      tail.last = 1'b1;
      expected_steps.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic bus_cmd_t mk_cmd(logic [MODE_W-1:0] m, logic [BYTE_W-1:0] v,
                                      logic a, logic [BYTE_W-1:0] l);
    bus_cmd_t c;
    c.mode = m;
    c.byte_value = v;
    c.send_ack = a;
    c.line_bits = l;
    return c;
  endfunction

  function automatic bus_cmd_t rand_cmd(logic [MODE_W-1:0] m);
    return mk_cmd(m, BYTE_W'($urandom), 1'($urandom), BYTE_W'($urandom));
  endfunction

  // Called and returns just after a falling edge; valid stays high across back-to-back sends
  task automatic send_command(bus_cmd_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= c.mode;
    in_ch.byte_value <= c.byte_value;
    in_ch.send_ack   <= c.send_ack;
    in_ch.line_bits  <= c.line_bits;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_line_changes(c);
    mode_count[c.mode]++;
    if (c.mode <= MODE_READ) commands_sent++;
    @(negedge clk);
  endtask

  // One bus transfer: start, data bytes, maybe a restart with more bytes, stop
  task automatic send_transfer();
    int n_bytes;
    send_command(rand_cmd(MODE_START));
    n_bytes = $urandom_range(1, 4);
    repeat (n_bytes) send_command(rand_cmd($urandom_range(1) ? MODE_WRITE : MODE_READ));
    if ($urandom_range(2) == 0) begin
      send_command(rand_cmd(MODE_RESTART));
      n_bytes = $urandom_range(1, 2);
      repeat (n_bytes) send_command(rand_cmd($urandom_range(1) ? MODE_WRITE : MODE_READ));
    end
    send_command(rand_cmd(MODE_STOP));
  endtask

  task automatic test_directed_commands();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_command(mk_cmd(MODE_START,   8'h00, 1'b1, 8'hFF));
    send_command(mk_cmd(MODE_WRITE,   8'hFF, 1'b1, 8'h00));
    send_command(mk_cmd(MODE_WRITE,   8'h00, 1'b0, 8'hFF));
    send_command(mk_cmd(MODE_READ,    8'h00, 1'b1, 8'hFF));
    send_command(mk_cmd(MODE_READ,    8'hFF, 1'b0, 8'h00));
    send_command(mk_cmd(MODE_RESTART, 8'hFF, 1'b0, 8'h00));
    send_command(mk_cmd(MODE_READ,    8'h00, 1'b1, 8'hA5));
    send_command(mk_cmd(MODE_WRITE,   8'h5A, 1'b1, 8'h00));
    send_command(mk_cmd(MODE_STOP,    8'hFF, 1'b1, 8'hFF));
    // unused mode codes: no line changes, levels must carry over untouched
    send_command(mk_cmd(3'd5, 8'hFF, 1'b1, 8'hFF));
    send_command(mk_cmd(3'd6, 8'h00, 1'b0, 8'h00));
    send_command(mk_cmd(3'd7, 8'hA5, 1'b1, 8'h5A));
    send_command(mk_cmd(MODE_STOP,    8'h00, 1'b0, 8'h00));
    send_command(mk_cmd(MODE_START,   8'hA5, 1'b0, 8'h00));
    send_command(mk_cmd(MODE_WRITE,   8'h80, 1'b0, 8'h00));
    send_command(mk_cmd(MODE_WRITE,   8'h01, 1'b0, 8'h00));
    send_command(mk_cmd(MODE_READ,    8'h00, 1'b0, 8'h5A));
    send_command(mk_cmd(MODE_READ,    8'h00, 1'b1, 8'h81));
    send_command(mk_cmd(MODE_RESTART, 8'h00, 1'b1, 8'hFF));
    send_command(mk_cmd(MODE_STOP,    8'h00, 1'b0, 8'h00));
  endtask

  task automatic test_random_traffic(int n_cmds, int tx_pct, int rx_pct);
    int first;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    first = commands_sent;
    while (commands_sent - first < n_cmds) begin
      if ($urandom_range(9) == 0) send_command(rand_cmd(MODE_W'($urandom)));
      else send_transfer();
    end
  endtask

  // Hold the result side off while commands keep coming, so the input stalls
  task automatic test_receiver_holdoff();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    @(posedge clk);
    hold_req_count++;
    @(negedge clk);
    send_command(rand_cmd(MODE_START));
    repeat (10) send_command(rand_cmd($urandom_range(1) ? MODE_WRITE : MODE_READ));
    send_command(rand_cmd(MODE_STOP));
  endtask

  // ---------------------------------------------------------------- result side

  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req_count) begin
        hold_seen = hold_req_count;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    step_t got;
    step_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{scl: out_ch.scl, sda: out_ch.sda, read_byte: out_ch.read_byte, last: out_ch.last};
      steps_checked++;
      if (expected_steps.size() == 0) begin
        line_errors++;
        if (line_errors <= 10)
          $display("%0t: unexpected line change scl=%b sda=%b read_byte=%02h last=%b",
                   $realtime, got.scl, got.sda, got.read_byte, got.last);
      end else begin
        want = expected_steps.pop_front();
        if (got !== want) begin
          line_errors++;
          if (line_errors <= 10)
            $display({"%0t: line change %0d: expected scl=%b sda=%b read_byte=%02h last=%b,",
                      " got scl=%b sda=%b read_byte=%02h last=%b"},
                     $realtime, steps_checked, want.scl, want.sda, want.read_byte, want.last,
                     got.scl, got.sda, got.read_byte, got.last);
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles, %0d line changes pending",
               quiet_cycles, expected_steps.size());
      $display("tb_i2c_master_byte_sequencer: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_STOP;
    in_ch.byte_value = '0;
    in_ch.send_ack   = 1'b0;
    in_ch.line_bits  = '0;
    rst_n            = 1'b0;
    tx_idle_pct      = 0;
    rx_stall_pct     = 0;
    hold_req_count   = 0;
    commands_sent    = 0;
    foreach (mode_count[m]) mode_count[m] = 0;
    scl_line = 1'b1;
    sda_line = 1'b1;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_commands();
    test_random_traffic(34, 0, 0);
    test_random_traffic(34, 69, 0);
    test_random_traffic(34, 0, 69);
    test_random_traffic(34, 28, 28);
    test_receiver_holdoff();
    in_ch.valid <= 1'b0;

    while (expected_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands: %0d start, %0d restart, %0d stop, %0d write, %0d read, %0d unused",
             commands_sent, mode_count[MODE_START], mode_count[MODE_RESTART],
             mode_count[MODE_STOP], mode_count[MODE_WRITE], mode_count[MODE_READ],
             mode_count[5] + mode_count[6] + mode_count[7]);
    $display("Checked %0d line changes over four idle mixes and a %0d-cycle result hold-off",
             steps_checked, HOLD_CYCLES);
    if (line_errors == 0) begin
      $display("tb_i2c_master_byte_sequencer: clean");
    end else begin
      $display("%0d mismatching or unexpected line changes", line_errors);
      $display("tb_i2c_master_byte_sequencer: errors");
    end
    $finish;
  end

endmodule
